// File: rtl/core/tvd_pkg.sv
// Shared constants, types and helpers for the TVD face reconstruction block.
`default_nettype none

package tvd_pkg;

    // Value format and derived widths
    localparam int VALUE_W     = 32;
    localparam int SUM_W       = VALUE_W + 2;
    localparam int WEIGHT_BITS = 16;
    localparam int WF_W        = WEIGHT_BITS + 1;

    // Shared divider: 48-bit dividend, 33-bit divisor, 17 quotient bits
    localparam int DIVD_W = 48;
    localparam int DIVR_W = VALUE_W + 1;
    localparam int QUOT_W = WF_W;
    localparam int CNT_W  = 5;

    // Shared multiplier: 17 x 32 bits
    localparam int PROD_W   = WF_W + VALUE_W;
    localparam int ROUND_SH = WEIGHT_BITS + 2;
    localparam int QMAG_W   = PROD_W - ROUND_SH;
    localparam int NUM_W    = 2 * WEIGHT_BITS;

    localparam logic [WF_W-1:0]   WF_ONE     = WF_W'(1) << WEIGHT_BITS;
    localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (ROUND_SH - 1);

    // One face computation request: west, centre, east plus tags
    typedef struct packed {
        logic signed [VALUE_W-1:0] w;
        logic signed [VALUE_W-1:0] p;
        logic signed [VALUE_W-1:0] e;
        logic                      row_end;
        logic                      burst_end;
    } job_t;

    // One finished result
    typedef struct packed {
        logic signed [VALUE_W-1:0] west_face;
        logic signed [VALUE_W-1:0] east_face;
        logic [WF_W-1:0]           limiter_weight;
        logic                      row_end;
        logic                      burst_end;
    } result_t;

    typedef enum logic [2:0] {
        T_IDLE,
        T_GO1,
        T_WAIT1,
        T_GO2,
        T_WAIT2
    } top_state_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIFF,
        S_CHECK,
        S_FDIV_GO,
        S_FDIV,
        S_MFG,
        S_MFF,
        S_MGG,
        S_DEN,
        S_WDIV_GO,
        S_WDIV,
        S_MQ,
        S_RND,
        S_FACE,
        S_DONE
    } core_state_t;

    // Clamp a widened sum to the signed value range
    function automatic logic signed [VALUE_W-1:0] sat_value(input logic signed [SUM_W-1:0] v);
        logic signed [VALUE_W-1:0] r;
        if (v[SUM_W-1:VALUE_W-1] == '0 || v[SUM_W-1:VALUE_W-1] == '1)
        begin
            r = v[VALUE_W-1:0];
        end
        else if (v[SUM_W-1])
        begin
            r = {1'b1, {(VALUE_W-1){1'b0}}};
        end
        else
        begin
            r = {1'b0, {(VALUE_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/tvd_face_reconstruction_top.sv
// Top level of the TVD face reconstruction block: window, handshakes, output register.
// Streams Q16.16 cells one request at a time and returns limited west/east face
// values one cell behind; a request with last_cell also flushes the row's last
// cell. Each result is produced by a sequencer around one restoring divider and
// one 17x32 multiplier. With the limiter active it uses two 17-step divisions for
// f and the weight, four multiply steps and one add besides start, window compare,
// rounding, face sums and handoff; when the window is an extremum or flat, or the
// span is within min_span, only start, window compare, face sums and handoff remain.
// After a request is taken, in_stall stays low for a row start only; otherwise it
// stays high until its one or two results reach the output register, also while a
// result waits for that register because out_stall is high. A finished result
// waits in the output register while the next request is taken. The block does not
// enforce that min_span is written with cfg_wr_en only while idle: a user duty.
`default_nettype none

module tvd_face_reconstruction_top
    import tvd_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_wr_en,
    input  wire logic [VALUE_W-1:0]        cfg_wr_data,
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire logic signed [VALUE_W-1:0] cell_value,
    input  wire logic signed [VALUE_W-1:0] left_ghost,
    input  wire logic signed [VALUE_W-1:0] right_ghost,
    input  wire logic                      first_cell,
    input  wire logic                      last_cell,
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic signed [VALUE_W-1:0]      west_face,
    output logic signed [VALUE_W-1:0]      east_face,
    output logic [WF_W-1:0]                limiter_weight,
    output logic                           row_end,
    output logic                           burst_end
);

    top_state_t state_reg;
    top_state_t state_next;

    logic [VALUE_W-1:0]        min_span_reg;
    logic signed [VALUE_W-1:0] west_reg;
    logic signed [VALUE_W-1:0] center_reg;
    logic                      win_valid_reg;
    job_t                      job1_reg;
    logic signed [VALUE_W-1:0] rg_reg;
    logic                      last_reg;
    logic                      out_valid_reg;
    result_t                   out_reg;

    logic    accept;
    logic    has_job1;
    logic    core_start;
    job_t    core_job;
    logic    core_res_valid;
    logic    core_res_ready;
    result_t core_res;
    logic    handoff;

    tvd_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (core_start),
        .job       (core_job),
        .min_span  (min_span_reg),
        .res_valid (core_res_valid),
        .res_ready (core_res_ready),
        .res       (core_res)
    );

    assign accept         = in_valid && !in_stall;
    assign has_job1       = !first_cell && win_valid_reg;
    assign core_res_ready = !out_valid_reg || !out_stall;
    assign handoff        = core_res_valid && core_res_ready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            T_IDLE:
            begin
                if (accept)
                begin
                    priority if (has_job1) state_next = T_GO1;
                    else if (last_cell)    state_next = T_GO2;
                    else                   state_next = T_IDLE;
                end
            end
            T_GO1:   state_next = T_WAIT1;
            T_WAIT1: if (handoff) state_next = last_reg ? T_GO2 : T_IDLE;
            T_GO2:   state_next = T_WAIT2;
            T_WAIT2: if (handoff) state_next = T_IDLE;
            default: state_next = T_IDLE;
        endcase
    end

    // Outputs of the control
    always_comb
    begin
        in_stall   = 1'b1;
        core_start = 1'b0;
        core_job   = job1_reg;
        unique case (state_reg)
            T_IDLE:
            begin
                in_stall = 1'b0;
            end
            T_GO1:
            begin
                core_start = 1'b1;
            end
            T_GO2:
            begin
                core_start         = 1'b1;
                core_job.w         = west_reg;
                core_job.p         = center_reg;
                core_job.e         = rg_reg;
                core_job.row_end   = 1'b1;
                core_job.burst_end = 1'b1;
            end
            default:
            begin
                core_start = 1'b0;
            end
        endcase
    end

    // Control state, window and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= T_IDLE;
            min_span_reg  <= '0;
            west_reg      <= '0;
            center_reg    <= '0;
            win_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                min_span_reg <= cfg_wr_data;
            end
            if (accept)
            begin
                if (has_job1)
                begin
                    west_reg <= center_reg;
                end
                else
                begin
                    west_reg <= left_ghost;
                end
                center_reg    <= cell_value;
                win_valid_reg <= !last_cell;
            end
            if (handoff)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Request capture and output payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            job1_reg.w         <= west_reg;
            job1_reg.p         <= center_reg;
            job1_reg.e         <= cell_value;
            job1_reg.row_end   <= 1'b0;
            job1_reg.burst_end <= !last_cell;
            rg_reg             <= right_ghost;
            last_reg           <= last_cell;
        end
        if (handoff)
        begin
            out_reg <= core_res;
        end
    end

    assign out_valid      = out_valid_reg;
    assign west_face      = out_reg.west_face;
    assign east_face      = out_reg.east_face;
    assign limiter_weight = out_reg.limiter_weight;
    assign row_end        = out_reg.row_end;
    assign burst_end      = out_reg.burst_end;

endmodule

`default_nettype wire

// File: rtl/core/tvd_div.sv
// Shared restoring divider, one quotient bit per cycle.
`default_nettype none

module tvd_div
    import tvd_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [DIVD_W-1:0] dividend,
    input  wire logic [DIVR_W-1:0] divisor,
    output logic                   done,
    output logic [QUOT_W-1:0]      quotient
);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [DIVR_W-1:0] rem_reg;
    logic [DIVR_W-1:0] divisor_reg;
    logic [QUOT_W-1:0] low_reg;
    logic [QUOT_W-1:0] quot_reg;

    logic [DIVR_W:0]   trial;
    logic [DIVR_W:0]   trial_diff;
    logic              trial_ge;

    // Trial subtract of the shifted remainder
    always_comb
    begin
        trial      = {rem_reg, low_reg[QUOT_W-1]};
        trial_diff = trial - {1'b0, divisor_reg};
        trial_ge   = (trial >= {1'b0, divisor_reg});
    end

    // Step control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CNT_W'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(QUOT_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // Remainder and quotient datapath; caller guarantees quotient fits QUOT_W bits
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg     <= DIVR_W'(dividend[DIVD_W-1:QUOT_W]);
            low_reg     <= dividend[QUOT_W-1:0];
            divisor_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg  <= trial_ge ? trial_diff[DIVR_W-1:0] : trial[DIVR_W-1:0];
            low_reg  <= {low_reg[QUOT_W-2:0], 1'b0};
            quot_reg <= {quot_reg[QUOT_W-2:0], trial_ge};
        end
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

`default_nettype wire

// File: rtl/core/tvd_core.sv
// Face sequencer: limiter weight and face values for one window, using the
// shared divider and one shared 17x32 multiplier.
`default_nettype none

module tvd_core
    import tvd_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire job_t               job,
    input  wire logic [VALUE_W-1:0] min_span,
    output logic                    res_valid,
    input  wire logic               res_ready,
    output result_t                 res
);

    core_state_t state_reg;
    core_state_t state_next;

    job_t              job_reg;
    logic [VALUE_W-1:0] ua_reg;
    logic [VALUE_W-1:0] ud_reg;
    logic              d_neg_reg;
    logic              mono_reg;
    logic [WEIGHT_BITS-1:0] f_reg;
    logic [WF_W-1:0]   g_reg;
    logic [NUM_W-1:0]  num_reg;
    logic [DIVR_W-1:0] den_reg;
    logic [WF_W-1:0]   wf_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [QMAG_W-1:0] qmag_reg;
    result_t           res_reg;

    logic signed [VALUE_W:0] diff_a;
    logic signed [VALUE_W:0] diff_b;
    logic signed [VALUE_W:0] diff_d;
    logic [VALUE_W:0]  mag_a;
    logic [VALUE_W:0]  mag_d;
    logic              take;

    logic              div_start;
    logic [DIVD_W-1:0] div_dividend;
    logic [DIVR_W-1:0] div_divisor;
    logic              div_done;
    logic [QUOT_W-1:0] div_quot;
    logic [DIVD_W-1:0] wdiv_num;

    logic [WF_W-1:0]    mul_a;
    logic [VALUE_W-1:0] mul_b;
    logic [PROD_W-1:0]  mul_p;
    logic [PROD_W-1:0]  rnd_sum;

    logic signed [SUM_W-1:0] p_ext;
    logic signed [SUM_W-1:0] q_mag_ext;
    logic signed [SUM_W-1:0] q_ext;
    logic signed [SUM_W-1:0] west_sum;
    logic signed [SUM_W-1:0] east_sum;

    tvd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    // Window differences
    always_comb
    begin
        diff_a = (VALUE_W+1)'(job_reg.p) - (VALUE_W+1)'(job_reg.w);
        diff_b = (VALUE_W+1)'(job_reg.e) - (VALUE_W+1)'(job_reg.p);
        diff_d = (VALUE_W+1)'(job_reg.e) - (VALUE_W+1)'(job_reg.w);
        mag_a  = diff_a[VALUE_W] ? -diff_a : diff_a;
        mag_d  = diff_d[VALUE_W] ? -diff_d : diff_d;
        take   = mono_reg && (ud_reg > min_span);
    end

    // Weight division numerator: 2fg * 2^16 + den/2
    assign wdiv_num = {num_reg, WEIGHT_BITS'(0)} + DIVD_W'(den_reg >> 1);

    assign mul_p   = mul_a * mul_b;
    assign rnd_sum = prod_reg + ROUND_HALF;

    // Face sums, q carries the sign of east minus west
    always_comb
    begin
        p_ext     = SUM_W'(job_reg.p);
        q_mag_ext = SUM_W'({1'b0, qmag_reg});
        q_ext     = d_neg_reg ? -q_mag_ext : q_mag_ext;
        west_sum  = p_ext - q_ext;
        east_sum  = p_ext + q_ext;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:    if (start) state_next = S_DIFF;
            S_DIFF:    state_next = S_CHECK;
            S_CHECK:   state_next = take ? S_FDIV_GO : S_FACE;
            S_FDIV_GO: state_next = S_FDIV;
            S_FDIV:    if (div_done) state_next = S_MFG;
            S_MFG:     state_next = S_MFF;
            S_MFF:     state_next = S_MGG;
            S_MGG:     state_next = S_DEN;
            S_DEN:     state_next = S_WDIV_GO;
            S_WDIV_GO: state_next = S_WDIV;
            S_WDIV:    if (div_done) state_next = S_MQ;
            S_MQ:      state_next = S_RND;
            S_RND:     state_next = S_FACE;
            S_FACE:    state_next = S_DONE;
            S_DONE:    if (res_ready) state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    // Shared unit controls
    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = {ua_reg, WEIGHT_BITS'(0)};
        div_divisor  = {1'b0, ud_reg};
        mul_a        = '0;
        mul_b        = '0;
        res_valid    = 1'b0;
        unique case (state_reg)
            S_FDIV_GO:
            begin
                div_start = 1'b1;
            end
            S_WDIV_GO:
            begin
                div_start    = 1'b1;
                div_dividend = wdiv_num;
                div_divisor  = den_reg;
            end
            S_MFG:
            begin
                mul_a = g_reg;
                mul_b = VALUE_W'(f_reg);
            end
            S_MFF:
            begin
                mul_a = WF_W'(f_reg);
                mul_b = VALUE_W'(f_reg);
            end
            S_MGG:
            begin
                mul_a = g_reg;
                mul_b = VALUE_W'(g_reg);
            end
            S_MQ:
            begin
                mul_a = wf_reg;
                mul_b = ud_reg;
            end
            S_DONE:
            begin
                res_valid = 1'b1;
            end
            default:
            begin
                res_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Datapath registers, stepped by the sequencer
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_p;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    job_reg <= job;
                end
            end
            S_DIFF:
            begin
                ua_reg    <= mag_a[VALUE_W-1:0];
                ud_reg    <= mag_d[VALUE_W-1:0];
                d_neg_reg <= diff_d[VALUE_W];
                mono_reg  <= (diff_a != '0) && (diff_b != '0)
                             && (diff_a[VALUE_W] == diff_b[VALUE_W]);
            end
            S_CHECK:
            begin
                if (!take)
                begin
                    wf_reg   <= '0;
                    qmag_reg <= '0;
                end
            end
            S_FDIV:
            begin
                if (div_done)
                begin
                    f_reg <= div_quot[WEIGHT_BITS-1:0];
                    g_reg <= WF_ONE - WF_W'(div_quot[WEIGHT_BITS-1:0]);
                end
            end
            S_MFF:
            begin
                num_reg <= {prod_reg[NUM_W-2:0], 1'b0};
            end
            S_MGG:
            begin
                den_reg <= prod_reg[DIVR_W-1:0];
            end
            S_DEN:
            begin
                den_reg <= den_reg + prod_reg[DIVR_W-1:0];
            end
            S_WDIV:
            begin
                if (div_done)
                begin
                    wf_reg <= (div_quot > WF_ONE) ? WF_ONE : div_quot;
                end
            end
            S_RND:
            begin
                qmag_reg <= rnd_sum[ROUND_SH +: QMAG_W];
            end
            S_FACE:
            begin
                res_reg.west_face      <= sat_value(west_sum);
                res_reg.east_face      <= sat_value(east_sum);
                res_reg.limiter_weight <= wf_reg;
                res_reg.row_end        <= job_reg.row_end;
                res_reg.burst_end      <= job_reg.burst_end;
            end
            default:
            begin
            end
        endcase
    end

    assign res = res_reg;

endmodule

`default_nettype wire

// File: rtl/core/tvd_checker.sv
// Port-level checker for the TVD face reconstruction block, bound to the top level.
`default_nettype none

module tvd_checker
    import tvd_pkg::*;
(
    input wire logic                      clk,
    input wire logic                      rst_n,
    input wire logic                      in_valid,
    input wire logic                      in_stall,
    input wire logic                      first_cell,
    input wire logic                      last_cell,
    input wire logic                      out_valid,
    input wire logic                      out_stall,
    input wire logic signed [VALUE_W-1:0] west_face,
    input wire logic signed [VALUE_W-1:0] east_face,
    input wire logic [WF_W-1:0]           limiter_weight,
    input wire logic                      row_end,
    input wire logic                      burst_end
);

    // A stalled result holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable({west_face, east_face, limiter_weight,
                                            row_end, burst_end}))
        else $error("stalled result changed");

    // Row start without row end produces no work
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && first_cell && !last_cell |=> !in_stall)
        else $error("row start request left the block busy");

    // Row end always flushes, so the block goes busy
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && last_cell |=> in_stall)
        else $error("row end request did not start a flush");

    // Result for a row's last cell always closes its burst
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && row_end |-> burst_end)
        else $error("row end result without burst end");

    // Limiter weight never exceeds one
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (limiter_weight <= WF_ONE))
        else $error("limiter weight above one");

endmodule

bind tvd_face_reconstruction_top tvd_checker u_tvd_checker (.*);

`default_nettype wire

// File: tb/tvd_face_reconstruction_top_tb.sv
// Testbench for the TVD face reconstruction block: directed rows, random rows, scoreboard.
`timescale 1ns / 1ps

module tvd_face_reconstruction_top_tb
    import tvd_pkg::*;
();

    localparam int  WATCHDOG_LIMIT = 4000;
    localparam int  SETTLE_CYCLES  = 200;
    localparam int  MAX_WAIT       = 17;
    localparam logic [VALUE_W-1:0] ONE = 32'h0001_0000;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_wr_en = 1'b0;
    logic [VALUE_W-1:0]        cfg_wr_data = '0;
    logic                      in_valid = 1'b0;
    logic                      in_stall;
    logic signed [VALUE_W-1:0] cell_value = '0;
    logic signed [VALUE_W-1:0] left_ghost = '0;
    logic signed [VALUE_W-1:0] right_ghost = '0;
    logic                      first_cell = 1'b0;
    logic                      last_cell = 1'b0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic signed [VALUE_W-1:0] west_face;
    logic signed [VALUE_W-1:0] east_face;
    logic [WF_W-1:0]           limiter_weight;
    logic                      row_end;
    logic                      burst_end;

    // Predictor state: open window and the min_span copy
    logic signed [VALUE_W-1:0] row_west = '0;
    logic signed [VALUE_W-1:0] row_center = '0;
    bit                        row_open = 1'b0;
    logic [VALUE_W-1:0]        span_limit = '0;
    result_t                   pending_faces[$];

    int mismatches = 0;
    int idle_cycles = 0;
    bit in_steady = 1'b0;
    bit out_steady = 1'b0;

    tvd_face_reconstruction_top u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .cell_value     (cell_value),
        .left_ghost     (left_ghost),
        .right_ghost    (right_ghost),
        .first_cell     (first_cell),
        .last_cell      (last_cell),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .west_face      (west_face),
        .east_face      (east_face),
        .limiter_weight (limiter_weight),
        .row_end        (row_end),
        .burst_end      (burst_end)
    );

    // Clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Clamp to the signed value range
    function automatic logic signed [VALUE_W-1:0] clamp_value(input longint v);
        longint hi;
        longint lo;
        hi = 64'sd2147483647;
        lo = -64'sd2147483648;
        if (v > hi)
            return hi[VALUE_W-1:0];
        if (v < lo)
            return lo[VALUE_W-1:0];
        return v[VALUE_W-1:0];
    endfunction

    // Van Albada limited faces for one window W, P, E
    function automatic result_t compute_faces(input longint w, input longint p, input longint e,
                                              input bit at_row_end, input bit at_burst_end);
        longint          a, b, d, q;
        longint unsigned ua, ud, r, f, g, num, den, wf, m;
        result_t         res;
        int              k;
        a  = p - w;
        b  = e - p;
        d  = e - w;
        ua = (a < 0) ? -a : a;
        ud = (d < 0) ? -d : d;
        wf = 0;
        q  = 0;
        if (((a > 0 && b > 0) || (a < 0 && b < 0)) && ud > longint'(span_limit))
        begin
            // f = |P-W| / |E-W| as Q0.16, restoring division
            r = ua;
            f = 0;
            for (k = 0; k < WEIGHT_BITS; k++)
            begin
                r = r << 1;
                f = f << 1;
                if (r >= ud)
                begin
                    r = r - ud;
                    f = f | 64'd1;
                end
            end
            g   = 64'd65536 - f;
            num = 64'd2 * f * g;
            den = f * f + g * g;
            wf  = ((num << WEIGHT_BITS) + den / 64'd2) / den;
            if (wf > 64'd65536)
                wf = 64'd65536;
            // q = |E-W| * wf / 4, rounded half away from zero
            m = ((wf * (ud >> 32)) << 14) + ((wf * (ud & 64'hFFFF_FFFF) + 64'd131072) >> 18);
            q = (d < 0) ? -longint'(m) : longint'(m);
        end
        res.west_face      = clamp_value(p - q);
        res.east_face      = clamp_value(p + q);
        res.limiter_weight = wf[WF_W-1:0];
        res.row_end        = at_row_end;
        res.burst_end      = at_burst_end;
        return res;
    endfunction

    // Advance the window for one accepted request
    function automatic void predict_cell(input logic signed [VALUE_W-1:0] cv,
                                         input logic signed [VALUE_W-1:0] lg,
                                         input logic signed [VALUE_W-1:0] rg,
                                         input bit fc, input bit lc);
        if (fc || !row_open)
        begin
            row_west   = lg;
            row_center = cv;
            row_open   = 1'b1;
        end
        else
        begin
            pending_faces.push_back(compute_faces(row_west, row_center, cv, 1'b0, !lc));
            row_west   = row_center;
            row_center = cv;
        end
        if (lc)
        begin
            pending_faces.push_back(compute_faces(row_west, row_center, rg, 1'b1, 1'b1));
            row_open = 1'b0;
        end
    endfunction

    function automatic int draw_wait(input bit steady);
        if (steady || $urandom_range(0, 3) == 0)
            return 0;
        return $urandom_range(0, MAX_WAIT);
    endfunction

    function automatic int field_differs(input string name, input logic [VALUE_W-1:0] want,
                                         input logic [VALUE_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    // Send one request; valid stays high when the next one follows at once
    task automatic send_cell(input logic [VALUE_W-1:0] cv, input logic [VALUE_W-1:0] lg,
                             input logic [VALUE_W-1:0] rg, input bit fc, input bit lc);
        int gap;
        gap = draw_wait(in_steady);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        cell_value  <= cv;
        left_ghost  <= lg;
        right_ghost <= rg;
        first_cell  <= fc;
        last_cell   <= lc;
        do @(posedge clk); while (in_stall !== 1'b0);
        predict_cell(cv, lg, rg, fc, lc);
    endtask

    // Wait until every expected result is back and the block has gone quiet
    task automatic drain_block();
        in_valid <= 1'b0;
        while (pending_faces.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_min_span(input logic [VALUE_W-1:0] span);
        drain_block();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= span;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        span_limit  = span;
    endtask

    // Rows of one cell: ghosts on both sides
    task automatic test_single_cell_rows();
        send_cell(ONE, 32'h0, 32'h0003_0000, 1'b1, 1'b1);
        send_cell(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 1'b1);
        send_cell(32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 1'b1);
        send_cell(32'hFFFF_0000, 32'h0002_0000, 32'hFFFC_0000, 1'b1, 1'b1);
        send_cell(32'h7FFF_FFFF, 32'h0, 32'h7FFF_FFFF, 1'b1, 1'b1);
    endtask

    // Full-range windows near both ends of the value range
    task automatic test_value_extremes();
        send_cell(32'h8000_0001, 32'h8000_0000, 32'h0, 1'b1, 1'b0);
        send_cell(32'h7FFF_FFFE, 32'h0, 32'h0, 1'b0, 1'b0);
        send_cell(32'h7FFF_FFFF, 32'h0, 32'h7FFF_FFFF, 1'b0, 1'b1);
    endtask

    // Peak, valley and flat windows give zero weight
    task automatic test_extrema_and_flats();
        send_cell(32'h0, 32'h0, 32'h0, 1'b1, 1'b0);
        send_cell(32'h0005_0000, 32'h0, 32'h0, 1'b0, 1'b0);
        send_cell(ONE, 32'h0, 32'h0, 1'b0, 1'b0);
        send_cell(ONE, 32'h0, 32'h0, 1'b0, 1'b0);
        send_cell(32'hFFFE_0000, 32'h0, 32'h0, 1'b0, 1'b1);
    endtask

    // Restart with a cell pending, and requests with no open row
    task automatic test_restart_and_orphans();
        send_cell(ONE, 32'h0, 32'h0, 1'b1, 1'b0);
        send_cell(32'h0002_0000, ONE, 32'h0, 1'b1, 1'b0);
        send_cell(32'h0003_0000, 32'h0, 32'h0, 1'b0, 1'b0);
        send_cell(32'h0004_0000, 32'h0, 32'h0005_0000, 1'b0, 1'b1);
        send_cell(32'h000A_0000, 32'h0009_0000, 32'h0, 1'b0, 1'b0);
        send_cell(32'h000C_0000, 32'h0, 32'h000D_0000, 1'b0, 1'b1);
        send_cell(32'h0000_8000, 32'hFFFF_0000, 32'h0002_0000, 1'b0, 1'b1);
    endtask

    // Span threshold: everything blocked, then a boundary of exactly min_span
    task automatic test_span_threshold();
        set_min_span(32'hFFFF_FFFF);
        send_cell(32'h0, 32'h8000_0000, 32'h0, 1'b1, 1'b0);
        send_cell(32'h4000_0000, 32'h0, 32'h7FFF_FFFF, 1'b0, 1'b1);
        set_min_span(32'h0002_0000);
        send_cell(ONE, 32'h0, 32'h0, 1'b1, 1'b0);
        send_cell(32'h0002_0000, 32'h0, 32'h0, 1'b0, 1'b0);
        send_cell(32'h0003_0001, 32'h0, 32'h0004_0001, 1'b0, 1'b1);
    endtask

    // Mostly well-formed rows of trending values with noise; some broken marks
    task automatic run_rows(input int n_items);
        int                 sent, len, k;
        logic [VALUE_W-1:0] val, slope, nmask;
        bit                 fc, lc;
        sent = 0;
        while (sent < n_items)
        begin
            in_steady  = ($urandom_range(0, 7) == 0);
            out_steady = ($urandom_range(0, 7) == 0);
            len   = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 10);
            val   = $urandom;
            slope = $urandom >> $urandom_range(1, 31);
            if ($urandom_range(0, 1))
                slope = -slope;
            nmask = 32'hFFFF_FFFF >> $urandom_range(4, 31);
            for (k = 0; k < len; k++)
            begin
                fc = (k == 0);
                lc = (k == len - 1);
                if ($urandom_range(0, 15) == 0)
                begin
                    fc = $urandom_range(0, 1);
                    lc = $urandom_range(0, 1);
                end
                if ($urandom_range(0, 15) == 0)
                    val = $urandom;
                else
                    val = val + slope + ($urandom & nmask) - (nmask >> 1);
                send_cell(val, $urandom, $urandom, fc, lc);
                sent++;
            end
        end
    endtask

    task automatic test_random_rows();
        set_min_span(32'h0);
        run_rows(300);
        set_min_span($urandom_range(0, 32'hFFFF));
        run_rows(200);
        set_min_span($urandom >> $urandom_range(8, 20));
        run_rows(200);
        set_min_span(32'h0);
        run_rows(200);
    endtask

    // Result side stall
    initial
    begin : result_stall
        int hold;
        forever
        begin
            hold = draw_wait(out_steady);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
                out_stall <= 1'b0;
            end
            do @(posedge clk); while (!(rst_n === 1'b1 && out_valid === 1'b1));
        end
    end

    // Scoreboard: compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_faces.size() == 0)
            begin
                $display("%0t: result with no request pending, actual %h %h %h %b %b", $time,
                         west_face, east_face, limiter_weight, row_end, burst_end);
                mismatches++;
            end
            else
            begin
                want = pending_faces.pop_front();
                mismatches += field_differs("west_face", want.west_face, west_face);
                mismatches += field_differs("east_face", want.east_face, east_face);
                mismatches += field_differs("limiter_weight", want.limiter_weight, limiter_weight);
                mismatches += field_differs("row_end", want.row_end, row_end);
                mismatches += field_differs("burst_end", want.burst_end, burst_end);
            end
        end
    end

    // Watchdog on cycles without any accepted request or result
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: watchdog expired, %0d results outstanding", $time,
                         pending_faces.size());
                $display("tvd_face_reconstruction_top_tb: FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        set_min_span(32'h0);
        test_single_cell_rows();
        test_value_extremes();
        test_extrema_and_flats();
        test_restart_and_orphans();
        test_span_threshold();
        test_random_rows();
        drain_block();
        if (mismatches == 0 && pending_faces.size() == 0)
            $display("tvd_face_reconstruction_top_tb: PASS");
        else
            $display("tvd_face_reconstruction_top_tb: FAIL");
        $finish;
    end

endmodule

// File: sim.f
rtl/core/tvd_pkg.sv
rtl/core/tvd_div.sv
rtl/core/tvd_core.sv
rtl/core/tvd_face_reconstruction_top.sv
rtl/core/tvd_checker.sv
tb/tvd_face_reconstruction_top_tb.sv
